/* src/rmd_pkg.sv */
// ----------------------------------------------------------------------------
// rmd_pkg: shared types and constants
// Result modes, error codes, limits and the divider stage word.
// ----------------------------------------------------------------------------
package rmd_pkg;

   localparam int DivBits = 63;

   typedef enum logic [1:0] {
      MODE_U8  = 2'd0,
      MODE_S16 = 2'd1,
      MODE_S32 = 2'd2,
      MODE_S64 = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_DZERO = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

   localparam logic [62:0] LimitU8  = 63'h0FF;
   localparam logic [62:0] LimitS16 = 63'h7FFF;
   localparam logic [62:0] LimitS32 = 63'h7FFF_FFFF;

   // word carried down the divider; nq holds remaining dividend bits on top
   // and finished quotient bits below
   typedef struct packed {
      logic [1:0]         mode;
      logic               neg;
      logic               dzero;
      logic [31:0]        den;
      logic [31:0]        rem;
      logic [DivBits-1:0] nq;
   } div_type;

endpackage

/* src/rmd_front.sv */
// ----------------------------------------------------------------------------
// rmd_front: magnitude, multiply and rounding stages
// Three registered stages producing the rounded dividend for the divider.
// ----------------------------------------------------------------------------
module rmd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       factor_a,
   input  logic [31:0]       factor_b,
   input  logic [31:0]       divisor,
   input  logic [1:0]        result_mode,
   output logic              out_valid,
   output rmd_pkg::div_type  out_word
);

   logic        va_ff, vb_ff, vc_ff;
   logic [31:0] ma_ff, mb_ff, md_ff, md2_ff;
   logic [1:0]  mode_a_ff, mode_b_ff;
   logic [63:0] prod_ff;
   rmd_pkg::div_type word_ff, word_in;

   // sign of the factor product and sign of the divisor, carried per stage
   logic        neg_a_ff, nd_a_ff;
   logic        prodneg_ff, dneg_ff;

   logic [31:0] ma_in, mb_in, md_in;
   logic        neg_in;

   always_comb begin
      ma_in = factor_a[31] ? (~factor_a + 32'd1) : factor_a;
      mb_in = factor_b[31] ? (~factor_b + 32'd1) : factor_b;
      md_in = divisor[31] ? (~divisor + 32'd1) : divisor;
      neg_in = factor_a[31] ^ factor_b[31];
   end

   always_comb begin
      word_in.mode  = mode_b_ff;
      word_in.neg   = ((prod_ff != 64'd0) && prodneg_ff) ^ dneg_ff;
      word_in.dzero = (md2_ff == 32'd0);
      word_in.den   = md2_ff;
      word_in.rem   = 32'd0;
      word_in.nq    = prod_ff[62:0] + {32'd0, md2_ff[31:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         md_ff      <= md_in;
         mode_a_ff  <= result_mode;
         neg_a_ff   <= neg_in;
         nd_a_ff    <= divisor[31];
         prod_ff    <= {32'd0, ma_ff} * {32'd0, mb_ff};
         md2_ff     <= md_ff;
         mode_b_ff  <= mode_a_ff;
         prodneg_ff <= neg_a_ff;
         dneg_ff    <= nd_a_ff;
         word_ff    <= word_in;
      end
   end

   always_comb begin
      out_word     = word_ff;
      out_valid    = vc_ff;
   end

endmodule

/* src/rmd_div_step.sv */
// ----------------------------------------------------------------------------
// rmd_div_step: one restoring division step
// Shift in one dividend bit, trial subtract, retire one quotient bit.
// ----------------------------------------------------------------------------
module rmd_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rmd_pkg::div_type  in_word,
   output logic              out_valid,
   output rmd_pkg::div_type  out_word
);

   logic             valid_ff;
   rmd_pkg::div_type word_ff, word_in;
   logic [32:0]      cand, diff;

   always_comb begin
      cand    = {in_word.rem, in_word.nq[rmd_pkg::DivBits-1]};
      diff    = cand - {1'b0, in_word.den};
      word_in = in_word;
      if (!diff[32]) begin
         word_in.rem = diff[31:0];
      end else begin
         word_in.rem = cand[31:0];
      end
      word_in.nq = {in_word.nq[rmd_pkg::DivBits-2:0], ~diff[32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* src/rmd_back.sv */
// ----------------------------------------------------------------------------
// rmd_back: mode clamp and sign
// Clamp or flag the quotient magnitude per mode and apply the sign.
// ----------------------------------------------------------------------------
module rmd_back (
   input  rmd_pkg::div_type  in_word,
   output logic [63:0]       quotient,
   output logic [1:0]        error_code
);

   logic [62:0] mag;
   logic        neg;
   logic [63:0] q;

   always_comb begin
      mag        = in_word.nq;
      neg        = in_word.neg;
      error_code = rmd_pkg::ERR_NONE;
      case (rmd_pkg::mode_type'(in_word.mode))
         rmd_pkg::MODE_U8: begin
            neg = 1'b0;
            if (mag > rmd_pkg::LimitU8) begin
               mag        = rmd_pkg::LimitU8;
               error_code = rmd_pkg::ERR_RANGE;
            end
         end
         rmd_pkg::MODE_S16: begin
            if (mag > rmd_pkg::LimitS16) begin
               mag        = rmd_pkg::LimitS16;
               error_code = rmd_pkg::ERR_RANGE;
            end
         end
         rmd_pkg::MODE_S32: begin
            if (mag > rmd_pkg::LimitS32) begin
               error_code = rmd_pkg::ERR_RANGE;
            end
         end
         default: ;
      endcase
      q = {1'b0, mag};
      if (neg) begin
         q = 64'd0 - q;
      end
      quotient = q;
      if (in_word.dzero) begin
         quotient   = 64'd0;
         error_code = rmd_pkg::ERR_DZERO;
      end
   end

endmodule

/* src/rounded_multiply_divide_unit.sv */
// ----------------------------------------------------------------------------
// rounded_multiply_divide_unit: signed multiply with rounded divide
// Pipeline: 3 front stages, 63 divider steps, 1 output register.
// Throughput one word per cycle unless rsp_stall holds the output; the 63 one-bit restoring steps set depth.
// The whole pipe holds while the output word waits under rsp_stall.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rounded_multiply_divide_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_factor_a,
   input  logic [31:0] req_factor_b,
   input  logic [31:0] req_divisor,
   input  logic [1:0]  req_result_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_quotient,
   output logic [1:0]  rsp_error_code
);

   localparam int N = rmd_pkg::DivBits;

   logic             en;
   logic             v   [0:N];
   rmd_pkg::div_type w   [0:N];
   logic             rsp_valid_ff;
   logic [63:0]      quotient_ff, quotient_in;
   logic [1:0]       error_ff, error_in;

   // advance everything unless the finished word is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   rmd_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .factor_a(req_factor_a), .factor_b(req_factor_b),
      .divisor(req_divisor), .result_mode(req_result_mode),
      .out_valid(v[0]), .out_word(w[0])
   );

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < N; i++) begin : g_div
      rmd_div_step u_step (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(v[i]), .in_word(w[i]),
         .out_valid(v[i+1]), .out_word(w[i+1])
      );
   end

   rmd_back u_back (
      .in_word(w[N]), .quotient(quotient_in), .error_code(error_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quotient_ff <= quotient_in;
         error_ff    <= error_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quotient   = quotient_ff;
   assign rsp_error_code = error_ff;

`ifndef SYNTHESIS
   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without held output");
   a_dzero_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == rmd_pkg::ERR_DZERO) |-> rsp_quotient == 64'd0)
      else $error("divide error with nonzero quotient");
   a_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == rmd_pkg::ERR_RANGE) |-> rsp_quotient != 64'd0)
      else $error("range error with zero quotient");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code != 2'd3)
      else $error("unused error code");
`endif

endmodule

/* sim/rounded_multiply_divide_unit_tb.sv */
// ----------------------------------------------------------------------------
// rounded_multiply_divide_unit_tb: self-checking bench for the multiply-divide
// Drives directed corner words and random words with random gaps, predicts each
// rounded, mode-clamped quotient and compares results in order.
// ----------------------------------------------------------------------------
module rounded_multiply_divide_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0]       fa;
      logic [31:0]       fb;
      logic [31:0]       dv;
      rmd_pkg::mode_type mode;
      bit                drain;   // hold the sender until every result has come
   } req_word_type;

   typedef struct {
      logic [63:0]      quotient;
      rmd_pkg::err_type err;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_factor_a = '0;
   logic [31:0] req_factor_b = '0;
   logic [31:0] req_divisor = '0;
   logic [1:0]  req_result_mode = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_quotient;
   logic [1:0]  rsp_error_code;

   req_word_type pending_words[$];
   rsp_word_type expected_quotients[$];
   int        fail_count = 0;
   bit        stim_done = 1'b0;
   int        idle_cycles = 0;
   localparam int IdleLimit = 2000;

   rounded_multiply_divide_unit dut (.*);

   always #4 clock = ~clock;

   // Compute the rounded, clamped quotient for one request word.
   function automatic rsp_word_type predict_quotient(req_word_type w);
      rsp_word_type r;
      logic [63:0] ma, mb, md, prod, q;
      bit          neg;
      ma = w.fa[31] ? 64'h1_0000_0000 - {32'b0, w.fa} : {32'b0, w.fa};
      mb = w.fb[31] ? 64'h1_0000_0000 - {32'b0, w.fb} : {32'b0, w.fb};
      md = w.dv[31] ? 64'h1_0000_0000 - {32'b0, w.dv} : {32'b0, w.dv};
      r.err = rmd_pkg::ERR_NONE;
      if (md == 0) begin
         r.quotient = '0;
         r.err = rmd_pkg::ERR_DZERO;
         return r;
      end
      prod = ma * mb;
      neg = ((prod != 0) && (w.fa[31] != w.fb[31])) != w.dv[31];
      q = (prod + (md >> 1)) / md;
      case (w.mode)
         rmd_pkg::MODE_U8: begin
            neg = 1'b0;
            if (q > 64'hFF) begin
               q = 64'hFF;
               r.err = rmd_pkg::ERR_RANGE;
            end
         end
         rmd_pkg::MODE_S16: begin
            if (q > 64'h7FFF) begin
               q = 64'h7FFF;
               r.err = rmd_pkg::ERR_RANGE;
            end
         end
         rmd_pkg::MODE_S32: begin
            if (q > 64'h7FFF_FFFF) r.err = rmd_pkg::ERR_RANGE;
         end
         default: ;
      endcase
      r.quotient = neg ? 64'd0 - q : q;
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 20) - 10;
         3: return $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_word(logic [31:0] a, logic [31:0] b, logic [31:0] d,
                            rmd_pkg::mode_type m, bit drain = 1'b0);
      req_word_type w;
      w.fa = a; w.fb = b; w.dv = d; w.mode = m; w.drain = drain;
      pending_words.push_back(w);
   endtask

   // Fill the stimulus queue: corners first, then random words.
   initial begin
      rmd_pkg::mode_type m;
      logic [31:0] d;
      for (int i = 0; i < 4; i++) begin
         m = rmd_pkg::mode_type'(i);
         push_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, m);
         push_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, m);
         push_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, m);
         push_word(32'd5, 32'd7, 32'd0, m);                // zero divisor
         push_word(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, m); // negative zero
         push_word(32'hFFFF_FFFB, 32'd1, 32'd2, m);         // half rounds away
      end
      push_word(32'd255, 32'd1, 32'd1, rmd_pkg::MODE_U8);
      push_word(32'd256, 32'd1, 32'd1, rmd_pkg::MODE_U8, 1'b1);
      for (int i = 0; i < 1150; i++) begin
         d = rand_operand();
         if ($urandom_range(0, 15) == 0) d = '0;
         else if ($urandom_range(0, 1)) d = $urandom_range(1, 4096);
         push_word(rand_operand(), rand_operand(), d,
                   rmd_pkg::mode_type'($urandom_range(0, 3)), (i == 600));
      end
      stim_done = 1'b1;
   end

   // Driver: present one word at a time after a random gap.
   int  send_gap = 0;
   bit  draining = 1'b0;
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_quotients.push_back(predict_quotient(pending_words[0]));
            draining = pending_words[0].drain;
            void'(pending_words.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         end
         if (!req_valid || !req_stall) begin
            // hold off while a drain pause is in effect or the gap counts down
            if (draining && expected_quotients.size() != 0) begin
               req_valid <= 1'b0;
            end else if (send_gap > 0) begin
               draining = 1'b0;
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               draining = 1'b0;
               req_valid       <= 1'b1;
               req_factor_a    <= pending_words[0].fa;
               req_factor_b    <= pending_words[0].fb;
               req_divisor     <= pending_words[0].dv;
               req_result_mode <= pending_words[0].mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result and draw the next stall length.
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_quotients.size() == 0) begin
               $error("result with no word pending: quotient %h", rsp_quotient);
               fail_count++;
            end else begin
               e = expected_quotients.pop_front();
               if (rsp_quotient !== e.quotient) begin
                  $error("quotient: expected %h actual %h", e.quotient, rsp_quotient);
                  fail_count++;
               end
               if (rsp_error_code !== e.err) begin
                  $error("error_code: expected %0d actual %0d", e.err, rsp_error_code);
                  fail_count++;
               end
            end
            stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_quotients.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_quotients.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
